FILE: rtl/dct_pkg.sv
// ----------------------------------------------------------------------------
// dct_pkg
// Shared constants and types of the disk collision time block.
// ----------------------------------------------------------------------------
package dct_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_W          = 23;
  localparam int DIFF_W        = IN_W + 1;
  localparam int RADIUS_W      = 22;
  localparam int TIME_W        = 32;
  localparam int MIN_MAG_W     = 2 * DIFF_W;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 22'd1966080;

  typedef enum logic [0:0] {
    CFG_OUTER_RADIUS   = 1'b0,
    CFG_ANNULUS_ENABLE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              hit;
    logic [TIME_W-1:0] ctime;
  } dct_res_t;

endpackage

FILE: rtl/disk_collision_time.sv
// ----------------------------------------------------------------------------
// disk_collision_time
// Time until two disks, or a disk and a moving circular wall, touch.
// ----------------------------------------------------------------------------
// The block takes one item in every cycle and never raises busy_o. Each
// result is shown on done_o for one cycle, in input order; the receiver
// has no way to hold it. The latency is set by the square root, which
// resolves one root bit per pipeline stage, and by the divider, which
// resolves one quotient bit per stage. Configuration writes take effect
// for items started afterward.
module disk_collision_time #(
  parameter int FracBits = dct_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               cfg_we_i,
  input  dct_pkg::cfg_idx_e                  cfg_idx_i,
  input  logic [dct_pkg::RADIUS_W-1:0]       cfg_wdata_i,
  input  logic                               opcode_i,
  input  logic signed [dct_pkg::IN_W-1:0]    a_pos_x_i,
  input  logic signed [dct_pkg::IN_W-1:0]    a_pos_y_i,
  input  logic signed [dct_pkg::IN_W-1:0]    a_vel_x_i,
  input  logic signed [dct_pkg::IN_W-1:0]    a_vel_y_i,
  input  logic signed [dct_pkg::IN_W-1:0]    b_pos_x_i,
  input  logic signed [dct_pkg::IN_W-1:0]    b_pos_y_i,
  input  logic signed [dct_pkg::IN_W-1:0]    b_vel_x_i,
  input  logic signed [dct_pkg::IN_W-1:0]    b_vel_y_i,
  output logic                               done_o,
  output logic                               hit_o,
  output logic [dct_pkg::TIME_W-1:0]         contact_time_o,
  output logic                               inner_wall_o
);
  import dct_pkg::*;

  localparam int MagW      = (2 * FracBits + 9 > MIN_MAG_W) ? 2 * FracBits + 9 : MIN_MAG_W;
  localparam int DW        = (FracBits + 5 > DIFF_W) ? FracBits + 5 : DIFF_W;
  localparam int PrW       = 2 * DIFF_W;
  localparam int SolveLat  = MagW + 39;
  localparam int Latency   = SolveLat + 4;

  logic [RADIUS_W-1:0] radius_q;
  logic                annulus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RADIUS_RST;
      annulus_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OUTER_RADIUS:   radius_q  <= cfg_wdata_i;
        CFG_ANNULUS_ENABLE: annulus_q <= cfg_wdata_i[0];
      endcase
    end
  end

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  logic                     s1_vld_q;
  logic                     s1_op_q;
  logic                     s1_en2_q;
  logic [RADIUS_W-1:0]      s1_radius_q;
  logic signed [DIFF_W-1:0] s1_dp0_q, s1_dp1_q, s1_dv0_q, s1_dv1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q     <= opcode_i;
    s1_en2_q    <= opcode_i & annulus_q;
    s1_radius_q <= radius_q;
    s1_dp0_q    <= DIFF_W'(a_pos_x_i) - DIFF_W'(b_pos_x_i);
    s1_dp1_q    <= DIFF_W'(a_pos_y_i) - DIFF_W'(b_pos_y_i);
    s1_dv0_q    <= DIFF_W'(a_vel_x_i) - DIFF_W'(b_vel_x_i);
    s1_dv1_q    <= DIFF_W'(a_vel_y_i) - DIFF_W'(b_vel_y_i);
  end

  logic signed [DW-1:0]   d1;
  logic signed [DW-1:0]   d9;
  logic signed [2*DW-1:0] d1_sq;
  logic signed [2*DW-1:0] d9_sq;
  assign d1 = $signed(DW'(s1_radius_q)) - $signed(DW'(1) << FracBits);
  assign d9 = $signed(DW'(s1_radius_q)) - $signed(DW'(9) << FracBits);
  assign d1_sq = d1 * d1;
  assign d9_sq = d9 * d9;

  logic                  s2_vld_q;
  logic                  s2_op_q;
  logic                  s2_en2_q;
  logic signed [PrW-1:0] s2_vv0_q, s2_vv1_q, s2_pv0_q, s2_pv1_q, s2_pp0_q, s2_pp1_q;
  logic [MagW-1:0]       s2_dsq1_q;
  logic [MagW-1:0]       s2_dsq2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_op_q   <= s1_op_q;
    s2_en2_q  <= s1_en2_q;
    s2_vv0_q  <= s1_dv0_q * s1_dv0_q;
    s2_vv1_q  <= s1_dv1_q * s1_dv1_q;
    s2_pv0_q  <= s1_dp0_q * s1_dv0_q;
    s2_pv1_q  <= s1_dp1_q * s1_dv1_q;
    s2_pp0_q  <= s1_dp0_q * s1_dp0_q;
    s2_pp1_q  <= s1_dp1_q * s1_dp1_q;
    s2_dsq1_q <= s1_op_q ? MagW'($unsigned(d1_sq)) : (MagW'(4) << (2 * FracBits));
    s2_dsq2_q <= MagW'($unsigned(d9_sq));
  end

  logic                  s3_vld_q;
  logic                  s3_op_q;
  logic                  s3_en2_q;
  logic [MagW-1:0]       s3_a_q;
  logic signed [MagW:0]  s3_h_q;
  logic signed [MagW:0]  s3_c1_q;
  logic signed [MagW:0]  s3_c2_q;
  logic [MagW-1:0]       dd;

  assign dd = MagW'($unsigned(s2_pp0_q)) + MagW'($unsigned(s2_pp1_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_op_q  <= s2_op_q;
    s3_en2_q <= s2_en2_q;
    s3_a_q   <= MagW'($unsigned(s2_vv0_q)) + MagW'($unsigned(s2_vv1_q));
    s3_h_q   <= (MagW+1)'(s2_pv0_q) + (MagW+1)'(s2_pv1_q);
    s3_c1_q  <= $signed({1'b0, dd}) - $signed({1'b0, s2_dsq1_q});
    s3_c2_q  <= $signed({1'b0, dd}) - $signed({1'b0, s2_dsq2_q});
  end

  dct_res_t res1;
  dct_res_t res2;

  dct_solve #(.FracBits(FracBits), .MagW(MagW)) u_solve_outer (
    .clk_i    (clk_i),
    .a_i      (s3_a_q),
    .h_i      (s3_h_q),
    .c_i      (s3_c1_q),
    .larger_i (s3_op_q),
    .res_o    (res1)
  );

  dct_solve #(.FracBits(FracBits), .MagW(MagW)) u_solve_inner (
    .clk_i    (clk_i),
    .a_i      (s3_a_q),
    .h_i      (s3_h_q),
    .c_i      (s3_c2_q),
    .larger_i (1'b0),
    .res_o    (res2)
  );

  logic [SolveLat-1:0] vld_pipe_q;
  logic [SolveLat-1:0] en2_pipe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_pipe_q <= '0;
    end else begin
      vld_pipe_q <= {vld_pipe_q[SolveLat-2:0], s3_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    en2_pipe_q <= {en2_pipe_q[SolveLat-2:0], s3_en2_q};
  end

  logic inner_d;
  assign inner_d = en2_pipe_q[SolveLat-1] && res2.hit
                && (!res1.hit || (res2.ctime < res1.ctime));

  logic              done_q;
  logic              hit_q;
  logic [TIME_W-1:0] time_q;
  logic              inner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_pipe_q[SolveLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= res1.hit || inner_d;
    inner_q <= inner_d;
    if (inner_d) begin
      time_q <= res2.ctime;
    end else if (res1.hit) begin
      time_q <= res1.ctime;
    end else begin
      time_q <= '0;
    end
  end

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign contact_time_o = time_q;
  assign inner_wall_o   = inner_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("result strobe missing after fixed latency");

  a_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (contact_time_o == '0 && !inner_wall_o))
    else $error("miss result carries a time or inner wall flag");

  a_inner_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && inner_wall_o) |-> (hit_o && contact_time_o != '0))
    else $error("inner wall flag without a valid contact");

endmodule

FILE: rtl/dct_mul.sv
// ----------------------------------------------------------------------------
// dct_mul
// Two-stage unsigned multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
module dct_mul #(
  parameter int W = 48
) (
  input  logic           clk_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] p_o
);

  localparam int L = W / 2;
  localparam int H = W - L;

  logic [2*L-1:0] ll_q;
  logic [L+H-1:0] lh_q;
  logic [L+H-1:0] hl_q;
  logic [2*H-1:0] hh_q;
  logic [2*W-1:0] p_d;
  logic [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    ll_q <= a_i[L-1:0] * b_i[L-1:0];
    lh_q <= (L+H)'(a_i[L-1:0]) * (L+H)'(b_i[W-1:L]);
    hl_q <= (L+H)'(a_i[W-1:L]) * (L+H)'(b_i[L-1:0]);
    hh_q <= a_i[W-1:L] * b_i[W-1:L];
  end

  assign p_d = (2*W)'(ll_q) + ((2*W)'(lh_q) << L) + ((2*W)'(hl_q) << L)
             + ((2*W)'(hh_q) << (2*L));

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

FILE: rtl/dct_solve.sv
// ----------------------------------------------------------------------------
// dct_solve
// Pipelined quadratic root: discriminant, digit-per-stage square root and a
// bit-per-stage restoring divider giving a saturated Q16.16 time.
// ----------------------------------------------------------------------------
module dct_solve #(
  parameter int FracBits = 16,
  parameter int MagW     = 48
) (
  input  logic                clk_i,
  input  logic [MagW-1:0]     a_i,
  input  logic signed [MagW:0] h_i,
  input  logic signed [MagW:0] c_i,
  input  logic                larger_i,
  output dct_pkg::dct_res_t   res_o
);
  import dct_pkg::*;

  localparam int PW    = 2 * MagW;
  localparam int DiscW = PW + 2;
  localparam int RemW  = PW + 2;
  localparam int SW    = MagW + 1;
  localparam int NSW   = SW + 2;
  localparam int NW    = SW + 1 + FracBits;

  typedef struct packed {
    logic [MagW-1:0]     a;
    logic signed [MagW:0] h;
    logic                larger;
    logic                cneg;
    logic                bad;
  } side_t;

  logic [MagW-1:0] hmag;
  logic [MagW-1:0] cmag;
  logic [PW-1:0]   hh;
  logic [PW-1:0]   ac;
  side_t           side_d;
  side_t           mul_side_q [0:1];

  assign hmag = (h_i < 0) ? MagW'(-h_i) : MagW'(h_i);
  assign cmag = (c_i < 0) ? MagW'(-c_i) : MagW'(c_i);

  assign side_d = '{a: a_i, h: h_i, larger: larger_i, cneg: (c_i < 0), bad: (a_i == '0)};

  dct_mul #(.W(MagW)) u_mul_hh (.clk_i(clk_i), .a_i(hmag), .b_i(hmag), .p_o(hh));
  dct_mul #(.W(MagW)) u_mul_ac (.clk_i(clk_i), .a_i(a_i),  .b_i(cmag), .p_o(ac));

  always_ff @(posedge clk_i) begin
    mul_side_q[0] <= side_d;
    mul_side_q[1] <= mul_side_q[0];
  end

  logic signed [DiscW-1:0] disc;
  side_t                   disc_side;

  always_comb begin
    disc_side = mul_side_q[1];
    if (disc_side.cneg) begin
      disc = $signed({2'b00, hh}) + $signed({2'b00, ac});
    end else begin
      disc = $signed({2'b00, hh}) - $signed({2'b00, ac});
    end
    disc_side.bad = mul_side_q[1].bad | disc[DiscW-1];
  end

  logic [RemW-1:0] sq_rem_q  [0:SW];
  logic [SW-1:0]   sq_root_q [0:SW];
  side_t           sq_side_q [0:SW];

  always_ff @(posedge clk_i) begin
    sq_rem_q[0]  <= $unsigned(disc);
    sq_root_q[0] <= '0;
    sq_side_q[0] <= disc_side;
  end

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    localparam int B = SW - 1 - k;
    logic [RemW-1:0] trial;
    assign trial = (RemW'(sq_root_q[k]) << (B + 1)) + (RemW'(1) << (2 * B));
    always_ff @(posedge clk_i) begin
      if (sq_rem_q[k] >= trial) begin
        sq_rem_q[k+1]  <= sq_rem_q[k] - trial;
        sq_root_q[k+1] <= sq_root_q[k] | (SW'(1) << B);
      end else begin
        sq_rem_q[k+1]  <= sq_rem_q[k];
        sq_root_q[k+1] <= sq_root_q[k];
      end
      sq_side_q[k+1] <= sq_side_q[k];
    end
  end

  logic signed [NSW-1:0] hx;
  logic signed [NSW-1:0] sx;
  logic signed [NSW-1:0] n;
  logic [NW-1:0]         num_q;
  logic [MagW-1:0]       num_a_q;
  logic                  num_bad_q;

  assign hx = NSW'(sq_side_q[SW].h);
  assign sx = $signed({2'b00, sq_root_q[SW]});
  assign n  = sq_side_q[SW].larger ? (sx - hx) : (-hx - sx);

  always_ff @(posedge clk_i) begin
    num_q     <= {n[SW:0], {FracBits{1'b0}}};
    num_a_q   <= sq_side_q[SW].a;
    num_bad_q <= sq_side_q[SW].bad | n[NSW-1] | (n == '0);
  end

  logic [MagW-1:0]   dv_rem_q [0:TIME_W];
  logic [TIME_W-1:0] dv_quo_q [0:TIME_W];
  logic [TIME_W-1:0] dv_low_q [0:TIME_W];
  logic [MagW-1:0]   dv_a_q   [0:TIME_W];
  logic              dv_sat_q [0:TIME_W];
  logic              dv_bad_q [0:TIME_W];

  always_ff @(posedge clk_i) begin
    dv_rem_q[0] <= MagW'(num_q >> TIME_W);
    dv_quo_q[0] <= '0;
    dv_low_q[0] <= num_q[TIME_W-1:0];
    dv_a_q[0]   <= num_a_q;
    dv_sat_q[0] <= (num_q >> TIME_W) >= NW'(num_a_q);
    dv_bad_q[0] <= num_bad_q;
  end

  for (genvar j = 0; j < TIME_W; j++) begin : g_div
    localparam int I = TIME_W - 1 - j;
    logic [MagW:0] r2;
    logic          ge;
    assign r2 = {dv_rem_q[j], dv_low_q[j][I]};
    assign ge = r2 >= {1'b0, dv_a_q[j]};
    always_ff @(posedge clk_i) begin
      dv_rem_q[j+1] <= ge ? MagW'(r2 - {1'b0, dv_a_q[j]}) : MagW'(r2);
      dv_quo_q[j+1] <= dv_quo_q[j] | (ge ? (TIME_W'(1) << I) : '0);
      dv_low_q[j+1] <= dv_low_q[j];
      dv_a_q[j+1]   <= dv_a_q[j];
      dv_sat_q[j+1] <= dv_sat_q[j];
      dv_bad_q[j+1] <= dv_bad_q[j];
    end
  end

  dct_res_t res_q;

  always_ff @(posedge clk_i) begin
    res_q.hit   <= !dv_bad_q[TIME_W] && (dv_sat_q[TIME_W] || (dv_quo_q[TIME_W] != '0));
    res_q.ctime <= dv_sat_q[TIME_W] ? '1 : dv_quo_q[TIME_W];
  end

  assign res_o = res_q;

endmodule

FILE: test/tb_disk_collision_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_disk_collision_time
// Self-checking bench for the disk collision time block. A directed table of
// contact cases comes first. Random disk-pair and wall items follow over
// several radius and annulus settings, with random start gaps. Typed table
// cases use fixed expected results, others a bit-exact fixed-point model.
// ----------------------------------------------------------------------------
module tb_disk_collision_time;
  import dct_pkg::*;

  localparam int  FRAC       = FRAC_BITS_DEF;
  localparam int  LATENCY    = 100;
  localparam int  RAND_ITEMS = 240;
  localparam int  NUM_PHASES = 5;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [IN_W-1:0] FMAX = 23'h3FFFFF;
  localparam logic [IN_W-1:0] FMIN = 23'h400000;

  typedef struct {
    logic                   op;
    logic signed [IN_W-1:0] apx, apy, avx, avy, bpx, bpy, bvx, bvy;
  } body_pair_t;

  typedef struct {
    logic              hit;
    logic [TIME_W-1:0] ctime;
    logic              inner;
  } contact_t;

  typedef struct {
    body_pair_t        pair;
    bit                typed;
    logic              hit;
    logic [TIME_W-1:0] ctime;
  } probe_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_idx_e cfg_idx_i = CFG_OUTER_RADIUS;
  logic [RADIUS_W-1:0] cfg_wdata_i = '0;
  logic opcode_i = 1'b0;
  logic signed [IN_W-1:0] a_pos_x_i = '0, a_pos_y_i = '0, a_vel_x_i = '0, a_vel_y_i = '0;
  logic signed [IN_W-1:0] b_pos_x_i = '0, b_pos_y_i = '0, b_vel_x_i = '0, b_vel_y_i = '0;
  logic busy_o, done_o, hit_o, inner_wall_o;
  logic [TIME_W-1:0] contact_time_o;

  contact_t pending_contacts[$];
  logic [RADIUS_W-1:0] radius_copy = RADIUS_RST;
  logic annulus_copy = 1'b0;
  int mismatches = 0;
  longint cycles = 0;
  int idle_pct = 0;

  disk_collision_time u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .opcode_i, .a_pos_x_i, .a_pos_y_i, .a_vel_x_i, .a_vel_y_i,
    .b_pos_x_i, .b_pos_y_i, .b_vel_x_i, .b_vel_y_i,
    .done_o, .hit_o, .contact_time_o, .inner_wall_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit root_time(longint a, longint h, longint c, bit larger,
                                   output logic [TIME_W-1:0] t);
    logic signed [129:0] hw, aw, cw, disc;
    logic [129:0] sq;
    logic [63:0] s, cand;
    logic [127:0] quo;
    longint n;
    t = '0;
    if (a <= 0) return 1'b0;
    hw = h;
    aw = a;
    cw = c;
    disc = hw * hw - aw * cw;
    if (disc < 0) return 1'b0;
    s = '0;
    for (int b = 62; b >= 0; b--) begin
      cand = s | (64'd1 << b);
      sq = 130'(cand) * 130'(cand);
      if (sq <= $unsigned(disc)) s = cand;
    end
    n = larger ? -h + longint'(s) : -h - longint'(s);
    if (n <= 0) return 1'b0;
    quo = (128'(n) << FRAC) / 128'(a);
    if (quo == 0) return 1'b0;
    t = (quo > 128'hFFFF_FFFF) ? '1 : quo[TIME_W-1:0];
    return 1'b1;
  endfunction

  function automatic contact_t predict_contact(body_pair_t p);
    longint dp0, dp1, dv0, dv1, a, h, dd, r, d1, d2;
    logic [TIME_W-1:0] t1, t2;
    bit h1, h2;
    contact_t res;
    dp0 = longint'(p.apx) - longint'(p.bpx);
    dp1 = longint'(p.apy) - longint'(p.bpy);
    dv0 = longint'(p.avx) - longint'(p.bvx);
    dv1 = longint'(p.avy) - longint'(p.bvy);
    a = dv0 * dv0 + dv1 * dv1;
    h = dp0 * dv0 + dp1 * dv1;
    dd = dp0 * dp0 + dp1 * dp1;
    res.inner = 1'b0;
    if (!p.op) begin
      d1 = longint'(2) << FRAC;
      h1 = root_time(a, h, dd - d1 * d1, 1'b0, t1);
    end else begin
      r = longint'(radius_copy);
      d1 = r - (longint'(1) << FRAC);
      h1 = root_time(a, h, dd - d1 * d1, 1'b1, t1);
      if (annulus_copy) begin
        d2 = r - (longint'(9) << FRAC);
        h2 = root_time(a, h, dd - d2 * d2, 1'b0, t2);
        if (h2 && (!h1 || t2 < t1)) begin
          res.inner = 1'b1;
          h1 = 1'b1;
          t1 = t2;
        end
      end
    end
    res.hit = h1;
    res.ctime = h1 ? t1 : '0;
    return res;
  endfunction

  function automatic longint srand(longint m);
    return longint'($urandom_range(int'(2 * m))) - m;
  endfunction

  function automatic body_pair_t random_pair();
    body_pair_t p;
    longint ox, oy, rr;
    p.op = $urandom_range(1);
    if ($urandom_range(9) < 2) begin
      {p.apx, p.apy, p.avx, p.avy} = {$urandom, $urandom, $urandom};
      {p.bpx, p.bpy, p.bvx, p.bvy} = {$urandom, $urandom, $urandom};
    end else if (!p.op) begin
      p.bpx = srand(1 << 20);
      p.bpy = srand(1 << 20);
      p.bvx = srand(1 << 18);
      p.bvy = srand(1 << 18);
      ox = srand(1 << 19);
      oy = srand(1 << 19);
      p.apx = p.bpx + ox;
      p.apy = p.bpy + oy;
      p.avx = p.bvx - (ox >>> $urandom_range(3)) + srand(1 << 16);
      p.avy = p.bvy - (oy >>> $urandom_range(3)) + srand(1 << 16);
    end else begin
      rr = longint'(radius_copy) * 15 / 16;
      p.bpx = srand(1 << 18);
      p.bpy = srand(1 << 18);
      p.bvx = srand(1 << 17);
      p.bvy = srand(1 << 17);
      p.apx = p.bpx + srand(rr);
      p.apy = p.bpy + srand(rr);
      p.avx = p.bvx + srand(1 << 18);
      p.avy = p.bvy + srand(1 << 18);
    end
    return p;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    mismatches++;
  endtask

  task automatic send_pair(body_pair_t p, contact_t want);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    opcode_i = p.op;
    {a_pos_x_i, a_pos_y_i, a_vel_x_i, a_vel_y_i} = {p.apx, p.apy, p.avx, p.avy};
    {b_pos_x_i, b_pos_y_i, b_vel_x_i, b_vel_y_i} = {p.bpx, p.bpy, p.bvx, p.bvy};
    do @(posedge clk_i); while (busy_o);
    pending_contacts.insert(pending_contacts.size(), want);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [RADIUS_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value;
    if (idx == CFG_OUTER_RADIUS) radius_copy = value;
    else annulus_copy = value[0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (pending_contacts.size() == 0) begin
        report_mismatch("unexpected result", 0, contact_time_o);
      end else begin
        contact_t want;
        want = pending_contacts.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", want.hit, hit_o);
        if (contact_time_o !== want.ctime)
          report_mismatch("contact_time", want.ctime, contact_time_o);
        if (inner_wall_o !== want.inner)
          report_mismatch("inner_wall", want.inner, inner_wall_o);
      end
    end
  end

  probe_t probes[16];
  logic [RADIUS_W-1:0] phase_radius[NUM_PHASES];
  logic phase_annulus[NUM_PHASES];
  int phase_idle[NUM_PHASES];

  initial begin
    contact_t want;
    probes[0]  = '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0};
    probes[1]  = '{'{1, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, 0};
    probes[2]  = '{'{0, 262144, 0, -65536, 0, 0, 0, 0, 0}, 1, 1, 32'h0002_0000};
    probes[3]  = '{'{0, 262144, 0, 65536, 0, 0, 0, 0, 0}, 1, 0, 0};
    probes[4]  = '{'{0, 0, 262144, 65536, 0, 0, 0, 0, 0}, 1, 0, 0};
    probes[5]  = '{'{1, 0, 0, 65536, 0, 0, 0, 0, 0}, 1, 1, 32'h001D_0000};
    probes[6]  = '{'{0, -3932160, 0, 1, 0, 0, 0, 0, 0}, 1, 1, 32'hFFFF_FFFF};
    probes[7]  = '{'{0, 262144, 131072, -65536, 0, 0, 0, 0, 0}, 1, 1, 32'h0004_0000};
    probes[8]  = '{'{0, 65536, 0, -65536, 0, 0, 0, 0, 0}, 1, 0, 0};
    probes[9]  = '{'{0, 65536, 0, 65536, 0, 0, 0, 0, 0}, 0, 0, 0};
    probes[10] = '{'{0, FMAX, FMAX, FMIN, FMIN, FMIN, FMIN, FMAX, FMAX}, 0, 0, 0};
    probes[11] = '{'{1, FMIN, FMAX, FMAX, FMIN, FMAX, FMIN, FMIN, FMAX}, 0, 0, 0};
    probes[12] = '{'{0, 131073, 0, FMIN, 0, 0, 0, FMAX, 0}, 0, 0, 0};
    probes[13] = '{'{1, 2621440, 0, 65536, 0, 0, 0, 0, 0}, 0, 0, 0};
    probes[14] = '{'{1, 0, 0, 0, 0, 0, 0, 65536, -32768}, 0, 0, 0};
    probes[15] = '{'{0, -131072, -655360, 7, 98304, 0, 0, -5, -3}, 0, 0, 0};
    phase_radius  = '{22'd4128768, 22'd131072, 22'd786432, 22'd655360, 22'd1966080};
    phase_annulus = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    phase_idle    = '{31, 31, 67, 67, 0};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    idle_pct = 31;
    foreach (probes[i]) begin
      want = predict_contact(probes[i].pair);
      if (probes[i].typed) begin
        want.hit = probes[i].hit;
        want.ctime = probes[i].ctime;
        want.inner = 1'b0;
      end
      send_pair(probes[i].pair, want);
    end
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 2) radius_copy = 22'($urandom_range(131072, 4128768));
      write_reg(CFG_OUTER_RADIUS, ph == 2 ? radius_copy : phase_radius[ph]);
      write_reg(CFG_ANNULUS_ENABLE, RADIUS_W'(phase_annulus[ph]));
      idle_pct = phase_idle[ph];
      repeat (RAND_ITEMS) begin
        body_pair_t p;
        p = random_pair();
        send_pair(p, predict_contact(p));
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
